// ===== rtl/fixed_frame_packet_splitter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// fixed frame packet splitter - assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FIXED_FRAME_PACKET_SPLITTER_UNIT_MACROS_SVH
`define FIXED_FRAME_PACKET_SPLITTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FFPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffps assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffps assertion failed");

`endif

// ===== rtl/ffps_pkg.sv =====
// ----------------------------------------------------------------------------
// ffps_pkg
// shared constants and control types of the frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

package ffps_pkg;

    localparam int unsigned FRAME_NS        = 20_000_000;
    localparam int          MAX_FRAMES_DEF  = 6;
    localparam int          MAX_CONCEAL_DEF = 32;

    localparam int NUM_SIZES = 3;
    localparam logic [4:0] FRAME_SIZES [NUM_SIZES] = '{5'd8, 5'd15, 5'd23};

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 80;

    typedef struct packed {
        logic load;
        logic emit;
    } ffps_cmd_t;

    typedef struct packed {
        logic in_loss;
        logic in_fit;
        logic last;
        logic out_free;
    } ffps_status_t;

endpackage

`default_nettype wire

// ===== rtl/ffps_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffps_ctrl
// sequencing state machine: accept and result emission
// ----------------------------------------------------------------------------
`default_nettype none

module ffps_ctrl
    import ffps_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  ffps_status_t      status,
    output ffps_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load = 1'b1;
                    if (status.in_loss || status.in_fit) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ffps_datapath.sv =====
// ----------------------------------------------------------------------------
// ffps_datapath
// size decode, gap count compare, time and offset accumulators, output register
// ----------------------------------------------------------------------------
`default_nettype none

module ffps_datapath
    import ffps_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int MAX_CONCEAL = MAX_CONCEAL_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [0:0]           s_tuser,
    input  ffps_cmd_t                 cmd,
    output ffps_status_t              status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                m_tuser,
    output logic                      m_tlast
);

    localparam int CNT_W  = ($clog2(MAX_CONCEAL + 1) > 3) ? $clog2(MAX_CONCEAL + 1) : 3;

    logic [15:0] in_len;
    logic [62:0] in_ts;
    logic        in_tv;
    logic        in_marker;
    logic [62:0] in_dur;
    logic        in_loss;

    assign in_len    = s_tdata[15:0];
    assign in_ts     = s_tdata[78:16];
    assign in_tv     = s_tdata[79];
    assign in_marker = s_tdata[80];
    assign in_dur    = s_tdata[143:81];
    assign in_loss   = s_tuser[0];

    logic             fit;
    logic [4:0]       fit_size;
    logic [2:0]       fit_cnt;
    logic             dur_zero;
    logic [CNT_W-1:0] dur_cnt;
    logic [CNT_W-1:0] base_cnt;
    logic [CNT_W-1:0] direct_cnt;

    logic [2:0]       rem_cnt_reg;

    logic             gap_reg;
    logic [62:0]      time_reg;
    logic             tv_reg;
    logic             disc_reg;
    logic [4:0]       size_reg;
    logic [6:0]       offset_reg;
    logic [CNT_W-1:0] remain_reg;

    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;
    logic             m_tlast_reg;

    // earlier sizes win, so they are written last
    always_comb begin
        fit      = 1'b0;
        fit_size = '0;
        fit_cnt  = '0;
        for (int j = NUM_SIZES - 1; j >= 0; j--) begin
            for (int q = MAX_FRAMES; q >= 1; q--) begin
                if (in_len == 16'(int'(FRAME_SIZES[j]) * q)) begin
                    fit      = 1'b1;
                    fit_size = FRAME_SIZES[j];
                    fit_cnt  = 3'(q);
                end
            end
        end
    end

    // whole frame periods in the loss, at least one and at most MAX_CONCEAL
    always_comb begin
        dur_cnt = CNT_W'(1);
        for (int k = 2; k <= MAX_CONCEAL; k++) begin
            if (in_dur >= 63'(64'(k) * 64'(FRAME_NS))) begin
                dur_cnt = CNT_W'(k);
            end
        end
    end

    assign dur_zero   = (in_dur == '0);
    assign base_cnt   = (rem_cnt_reg != '0) ? CNT_W'(rem_cnt_reg) : CNT_W'(1);
    assign direct_cnt = !dur_zero ? dur_cnt :
                        (base_cnt > CNT_W'(MAX_CONCEAL)) ? CNT_W'(MAX_CONCEAL) : base_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load && !in_loss && fit) begin
                rem_cnt_reg <= fit_cnt;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gap_reg    <= in_loss;
            time_reg   <= in_ts;
            tv_reg     <= in_tv;
            offset_reg <= '0;
            if (in_loss) begin
                size_reg   <= '0;
                disc_reg   <= 1'b1;
                remain_reg <= direct_cnt;
            end else begin
                size_reg   <= fit_size;
                disc_reg   <= in_marker;
                remain_reg <= CNT_W'(fit_cnt);
            end
        end else if (cmd.emit) begin
            time_reg   <= time_reg + 63'(FRAME_NS);
            offset_reg <= offset_reg + 7'(size_reg);
            disc_reg   <= 1'b0;
            remain_reg <= remain_reg - CNT_W'(1);
        end
        if (cmd.emit) begin
            m_tdata_reg <= {3'b000, disc_reg, tv_reg, (tv_reg ? time_reg : 63'd0),
                            size_reg, offset_reg};
            m_tuser_reg <= gap_reg;
            m_tlast_reg <= (remain_reg == CNT_W'(1));
        end
    end

    assign status.in_loss  = in_loss;
    assign status.in_fit   = fit;
    assign status.last     = (remain_reg == CNT_W'(1));
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/fixed_frame_packet_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_frame_packet_splitter_unit
// splits voice packets into frame descriptors and expands losses into gaps
// ----------------------------------------------------------------------------
// One item is worked at a time. A packet item is accepted and then gives N
// frame descriptors for N frames (N up to MAX_FRAMES); an unsplittable packet
// is accepted and gives nothing. A loss item likewise is accepted and then
// gives its gap descriptors, up to MAX_CONCEAL of them; its gap count is found
// in the accept cycle by comparing the loss duration against whole multiples
// of 20 ms, or for a zero duration taken from the last split packet's frame
// count. The single output register sends one descriptor per cycle; a stalled
// result stretches the run. The last descriptor of an item may still wait in
// the output register while the next item is being accepted. Nothing is
// accepted while reset is held.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_frame_packet_splitter_unit
    import ffps_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int MAX_CONCEAL = MAX_CONCEAL_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input transfers
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pkt_len[15:0], time_stamp[78:16], time_valid[79], marker_bit[80],
    // loss_duration[143:81]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0]: 0 received packet, 1 lost-packet event
    input  wire logic [0:0]           s_tuser,
    // result transfers
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // frame_offset[6:0], frame_bytes[11:7], frame_time[74:12],
    // frame_time_valid[75], discont[76], zero pad[79:77]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // is_gap[0]
    output logic [0:0]                m_tuser,
    // last_of_run: final descriptor of the item
    output logic                      m_tlast
);

    ffps_cmd_t    cmd;
    ffps_status_t status;

    // sequencer: idle/accept, emit
    ffps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // decode, gap count, accumulators and output register
    ffps_datapath #(
        .MAX_FRAMES  (MAX_FRAMES),
        .MAX_CONCEAL (MAX_CONCEAL)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/ffps_checker.sv =====
// ----------------------------------------------------------------------------
// ffps_checker
// port-level checks on result transfers of the frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_frame_packet_splitter_unit_macros.svh"

module ffps_checker
    import ffps_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]           m_tuser
);

    // a stalled result stays offered
    `FFPS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // gap descriptors carry no offset and no size
    `FFPS_ASSERT_NOW(a_gap_empty, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[11:0] == 12'd0)

    // real frames use one of the three sizes
    `FFPS_ASSERT_NOW(a_real_size, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[11:7] == 5'd8 || m_tdata[11:7] == 5'd15 || m_tdata[11:7] == 5'd23)

    // invalid time reads as zero
    `FFPS_ASSERT_NOW(a_time_zero, aclk, aresetn, m_tvalid && !m_tdata[75], m_tdata[74:12] == 63'd0)

endmodule

bind fixed_frame_packet_splitter_unit ffps_checker u_ffps_checker (.*);

`default_nettype wire

// ===== bench/fixed_frame_packet_splitter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_packet_splitter_unit_test
// self-checking bench for the voice frame splitter: a directed set of packet
// and loss transfers, then random traffic, with every frame descriptor checked
// against a typed value or a cycle-free prediction of the splitter
// ----------------------------------------------------------------------------

module fixed_frame_packet_splitter_unit_test
    import ffps_pkg::*;
;

    localparam int          CLK_PERIOD = 10;
    localparam int          RESET_CYCLES = 11;
    localparam int          RANDOM_ITEMS = 75;
    localparam int          QUIET_ITEMS = 30;     // opening random stretch with no idling
    localparam int          HOLD_AT_ITEM = 45;    // random item at which the sink holds off
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES = 64;    // extra wait after the expected descriptors are all seen
    localparam logic [62:0] MAX_STAMP = '1;
    localparam logic [62:0] MS20 = 63'(FRAME_NS);

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_LOSS   = 1'b1
    } voice_cmd_e;

    // how a directed row gets its expected descriptors
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_ONE_FRAME,
        ROW_NO_FRAME
    } row_check_e;

    typedef struct packed {
        voice_cmd_e  cmd;
        logic [15:0] pkt_len;
        logic [62:0] stamp;
        logic        stamp_ok;
        logic        marker;
        logic [62:0] loss_ns;
    } voice_item_t;

    typedef struct packed {
        logic        is_gap;
        logic [6:0]  offset;
        logic [4:0]  size;
        logic [62:0] stamp;
        logic        stamp_ok;
        logic        discont;
        logic        last;
    } frame_desc_t;

    typedef struct packed {
        voice_item_t item;
        row_check_e  check;
        frame_desc_t typed;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    frame_desc_t   frame_q[$];        // descriptors still owed by the splitter
    directed_row_t directed_rows[$];
    logic [2:0]    held_frame_count;  // frame count of the last split packet
    int            mismatch_count = 0;
    bit            quiet = 1'b0;      // no idling on either side while set
    bit            hold_req = 1'b0;   // asks the sink for one long hold-off

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    fixed_frame_packet_splitter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic frame_desc_t make_desc(logic gap, logic [6:0] off, logic [4:0] size,
                                              logic [62:0] stamp, logic ok, logic disc,
                                              logic last);
        frame_desc_t d;
        d.is_gap   = gap;
        d.offset   = off;
        d.size     = size;
        d.stamp    = ok ? stamp : '0;
        d.stamp_ok = ok;
        d.discont  = disc;
        d.last     = last;
        return d;
    endfunction

    function automatic voice_item_t make_item(voice_cmd_e cmd, logic [15:0] len,
                                              logic [62:0] stamp, logic ok, logic marker,
                                              logic [62:0] loss_ns);
        voice_item_t it;
        it.cmd         = cmd;
        it.pkt_len     = len;
        it.stamp       = stamp;
        it.stamp_ok    = ok;
        it.marker      = marker;
        it.loss_ns     = loss_ns;
        return it;
    endfunction

    function automatic void add_row(voice_item_t it, row_check_e check, frame_desc_t typed);
        directed_row_t r;
        r.item  = it;
        r.check = check;
        r.typed = typed;
        directed_rows.push_back(r);
    endfunction

    // works out the descriptors of one item and updates the held frame count;
    // with keep clear only the state moves on
    function automatic void split_item(voice_item_t it, bit keep);
        int unsigned sizes[3] = '{8, 15, 23};
        int unsigned len;
        int unsigned size;
        int unsigned count;
        logic [62:0] quot;
        logic [62:0] stamp;
        len   = 32'(it.pkt_len);
        size  = 0;
        count = 0;
        stamp = it.stamp;
        if (it.cmd == CMD_PACKET) begin
            // first size giving one to MAX_FRAMES whole frames wins
            for (int j = 0; j < 3; j++) begin
                if (count == 0 && len % sizes[j] == 0 && len / sizes[j] >= 1
                        && len / sizes[j] <= MAX_FRAMES_DEF) begin
                    size  = sizes[j];
                    count = len / sizes[j];
                end
            end
            if (count == 0) begin
                return;
            end
            held_frame_count = 3'(count);
        end else begin
            count = (held_frame_count != '0) ? 32'(held_frame_count) : 32'd1;
            if (it.loss_ns != 0) begin
                quot = it.loss_ns / MS20;
                if (quot < 1) begin
                    quot = 63'd1;
                end
                if (quot > MAX_CONCEAL_DEF) begin
                    quot = 63'(MAX_CONCEAL_DEF);
                end
                count = 32'(quot);
            end
            if (count > MAX_CONCEAL_DEF) begin
                count = 32'(MAX_CONCEAL_DEF);
            end
        end
        for (int unsigned i = 0; i < count; i++) begin
            if (keep) begin
                if (it.cmd == CMD_PACKET) begin
                    frame_q.push_back(make_desc(1'b0, 7'(i * size), 5'(size), stamp,
                                                it.stamp_ok, (i == 0) ? it.marker : 1'b0,
                                                i + 1 == count));
                end else begin
                    frame_q.push_back(make_desc(1'b1, '0, '0, stamp, it.stamp_ok, i == 0,
                                                i + 1 == count));
                end
            end
            stamp = stamp + MS20;   // wraps at 63 bits
        end
    endfunction

    function automatic voice_item_t random_item();
        int unsigned sizes[3] = '{8, 15, 23};
        int unsigned pick;
        voice_item_t it;
        pick = $urandom_range(0, 99);
        it.stamp       = 63'({$urandom, $urandom});
        it.stamp_ok    = ($urandom_range(0, 9) != 0);
        it.marker      = 1'($urandom_range(0, 1));
        it.pkt_len     = 16'($urandom);
        it.loss_ns     = 63'({$urandom, $urandom});
        if ($urandom_range(0, 7) == 0) begin
            it.stamp = MAX_STAMP - 63'($urandom_range(0, 200_000_000));
        end
        if (pick < 50) begin
            // well-formed packet of one to MAX_FRAMES frames
            it.cmd = CMD_PACKET;
            it.pkt_len = 16'(sizes[$urandom_range(0, 2)] * $urandom_range(1, MAX_FRAMES_DEF));
        end else if (pick < 62) begin
            it.cmd = CMD_PACKET;
            if ($urandom_range(0, 1) == 0) begin
                it.pkt_len = 16'($urandom_range(0, 160));
            end
        end else begin
            it.cmd = CMD_LOSS;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                it.loss_ns = '0;
            end else if (pick < 85) begin
                it.loss_ns = 63'($urandom_range(1, 700_000_000));
            end
        end
        return it;
    endfunction

    // offers one item, with a random idle spell in front, and waits for the transfer
    task automatic send_item(voice_item_t it);
        int idle;
        if (!quiet && $urandom_range(0, 99) < 18) begin
            idle = $urandom_range(1, 6);
            repeat (idle) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.loss_ns, it.marker, it.stamp_ok, it.stamp, it.pkt_len};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    function automatic void check_field(string name, logic [62:0] want, logic [62:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // sink side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // result checking, one descriptor per output transfer
    always @(posedge aclk) begin
        frame_desc_t want;
        frame_desc_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.is_gap   = m_tuser[0];
            got.offset   = m_tdata[6:0];
            got.size     = m_tdata[11:7];
            got.stamp    = m_tdata[74:12];
            got.stamp_ok = m_tdata[75];
            got.discont  = m_tdata[76];
            got.last     = m_tlast;
            if (frame_q.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected descriptor, expected none, actual %p", $time, got);
            end else begin
                want = frame_q.pop_front();
                check_field("is_gap", 63'(want.is_gap), 63'(got.is_gap));
                check_field("frame_offset", 63'(want.offset), 63'(got.offset));
                check_field("frame_bytes", 63'(want.size), 63'(got.size));
                check_field("frame_time", want.stamp, got.stamp);
                check_field("frame_time_valid", 63'(want.stamp_ok), 63'(got.stamp_ok));
                check_field("discont", 63'(want.discont), 63'(got.discont));
                check_field("last_of_run", 63'(want.last), 63'(got.last));
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        voice_item_t it;
        held_frame_count = '0;

        // directed rows: extremes, both commands and the special cases
        // first loss after reset falls back to a single gap
        add_row(make_item(CMD_LOSS, 16'd0, 63'd1000, 1'b1, 1'b0, '0), ROW_ONE_FRAME,
                make_desc(1'b1, '0, '0, 63'd1000, 1'b1, 1'b1, 1'b1));
        // empty packet cannot be split
        add_row(make_item(CMD_PACKET, 16'd0, '0, 1'b1, 1'b1, '0), ROW_NO_FRAME, '0);
        // smallest frame, marked, time zero
        add_row(make_item(CMD_PACKET, 16'd8, '0, 1'b1, 1'b1, '0), ROW_ONE_FRAME,
                make_desc(1'b0, '0, 5'd8, '0, 1'b1, 1'b1, 1'b1));
        // single largest frame at the top of the time range
        add_row(make_item(CMD_PACKET, 16'd23, MAX_STAMP, 1'b1, 1'b0, '0), ROW_ONE_FRAME,
                make_desc(1'b0, '0, 5'd23, MAX_STAMP, 1'b1, 1'b0, 1'b1));
        // six small frames, time wraps mid run
        add_row(make_item(CMD_PACKET, 16'd48, MAX_STAMP - 63'd5_000_000, 1'b1, 1'b1, '0),
                ROW_PREDICTED, '0);
        // seven small frames are too many
        add_row(make_item(CMD_PACKET, 16'd56, 63'd77, 1'b1, 1'b0, '0), ROW_NO_FRAME, '0);
        add_row(make_item(CMD_PACKET, 16'd90, 63'd123_456, 1'b1, 1'b0, '0), ROW_PREDICTED, '0);
        // largest offset, six frames of 23 bytes
        add_row(make_item(CMD_PACKET, 16'd138, 63'd999, 1'b1, 1'b1, MAX_STAMP), ROW_PREDICTED,
                '0);
        add_row(make_item(CMD_PACKET, 16'd120, 63'd5, 1'b1, 1'b0, '0), ROW_NO_FRAME, '0);
        add_row(make_item(CMD_PACKET, 16'd65535, MAX_STAMP, 1'b1, 1'b1, MAX_STAMP),
                ROW_NO_FRAME, '0);
        // invalid time zeroes every frame time
        add_row(make_item(CMD_PACKET, 16'd45, 63'd424_242, 1'b0, 1'b1, '0), ROW_PREDICTED, '0);
        // loss with no duration repeats the held count, ignored fields set
        add_row(make_item(CMD_LOSS, 16'hFFFF, 63'd50_000, 1'b1, 1'b1, '0), ROW_PREDICTED, '0);
        // duration below one frame still gives one gap
        add_row(make_item(CMD_LOSS, 16'd0, 63'd12_345, 1'b1, 1'b0, 63'd1), ROW_ONE_FRAME,
                make_desc(1'b1, '0, '0, 63'd12_345, 1'b1, 1'b1, 1'b1));
        add_row(make_item(CMD_LOSS, 16'd0, 63'd7, 1'b0, 1'b0, 63'd19_999_999), ROW_ONE_FRAME,
                make_desc(1'b1, '0, '0, '0, 1'b0, 1'b1, 1'b1));
        add_row(make_item(CMD_LOSS, 16'd0, 63'd1, 1'b1, 1'b0, 63'd39_999_999), ROW_PREDICTED,
                '0);
        add_row(make_item(CMD_LOSS, 16'd0, 63'd2, 1'b1, 1'b0, 63'd40_000_000), ROW_PREDICTED,
                '0);
        // longest losses saturate the gap count
        add_row(make_item(CMD_LOSS, 16'd0, '0, 1'b1, 1'b0, MAX_STAMP), ROW_PREDICTED, '0);
        add_row(make_item(CMD_LOSS, 16'd0, 63'd3, 1'b1, 1'b0, 63'd640_000_000), ROW_PREDICTED,
                '0);
        add_row(make_item(CMD_LOSS, 16'd0, 63'd4, 1'b1, 1'b0, 63'd659_999_999), ROW_PREDICTED,
                '0);
        add_row(make_item(CMD_LOSS, 16'd0, 63'd9, 1'b0, 1'b0, 63'd100_000_000), ROW_PREDICTED,
                '0);
        add_row(make_item(CMD_PACKET, 16'd16, 63'd11, 1'b1, 1'b0, MAX_STAMP), ROW_PREDICTED,
                '0);
        add_row(make_item(CMD_PACKET, 16'd30, MAX_STAMP, 1'b1, 1'b1, '0), ROW_PREDICTED, '0);
        // gap times wrap too
        add_row(make_item(CMD_LOSS, 16'd0, MAX_STAMP - 63'd30_000_000, 1'b1, 1'b0,
                          63'd200_000_000), ROW_PREDICTED, '0);
        add_row(make_item(CMD_PACKET, 16'd24, 63'd31, 1'b1, 1'b0, '0), ROW_PREDICTED, '0);
        add_row(make_item(CMD_LOSS, 16'd0, 63'd32, 1'b1, 1'b0, '0), ROW_PREDICTED, '0);

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].item);
            split_item(directed_rows[k].item, directed_rows[k].check == ROW_PREDICTED);
            if (directed_rows[k].check == ROW_ONE_FRAME) begin
                frame_q.push_back(directed_rows[k].typed);
            end
        end

        // random traffic: a quiet opening stretch, then idling and one long hold-off
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            quiet = (k < QUIET_ITEMS);
            if (k == HOLD_AT_ITEM) begin
                hold_req = 1'b1;
            end
            it = random_item();
            send_item(it);
            split_item(it, 1'b1);
        end
        quiet = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (frame_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && frame_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
